FILE: hw/rtl/vppc_pkg.sv
// shared types, widths and constants of the velocity pid pwm controller
package vppc_pkg;

  localparam int RATE_W     = 16;
  localparam int SETPOINT_W = 16;
  localparam int GAIN_W     = 40;
  localparam int DUTY_W     = 10;
  localparam int RPM_W      = 14;
  localparam int ERR_W      = 18;
  localparam int SUM_W      = 32;
  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;

  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 8'd3;

  localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 16'd250;
  localparam logic [GAIN_W-1:0]     KP_RST       = 40'd42949673;
  localparam logic [GAIN_W-1:0]     KI_RST       = 40'd4295;
  localparam logic [GAIN_W-1:0]     KD_RST       = 40'd0;

  // floor(2^20/11) and floor(2^26/333), each followed by one correction step
  localparam logic [MUL_A_W-1:0] RPM_RECIP  = 20'd95325;
  localparam logic [MUL_A_W-1:0] DUTY_RECIP = 20'd201528;
  localparam logic [16:0]        RPM_DIV    = 17'd11;
  localparam logic [18:0]        DRIVE_FULL = 19'd333;
  localparam logic [DUTY_W-1:0]  DUTY_FULL  = 10'd624;

  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint_rpm;
    logic [GAIN_W-1:0]     gain_proportional;
    logic [GAIN_W-1:0]     gain_integral_scaled;
    logic [GAIN_W-1:0]     gain_derivative_scaled;
  } cfg_regs_t;

endpackage

FILE: hw/rtl/velocity_pid_pwm_controller.sv
// velocity pid controller top level: sequencer, state and output register
// Usage:
//   in_*  : one beat per control tick, in_tdata[15:0] = pulse_rate.
//   out_* : one beat per tick, out_tdata[9:0] = pwm_duty, [23:10] = measured_rpm.
//   cfg_* : register writes (0 setpoint, 1 kp, 2 ki*T, 3 kd/T), always ready;
//           write only while no tick is in flight. Unknown indexes are dropped.
// Flow:
//   in_tready is high only while the sequencer is idle, so a new tick is not
//   taken until the last one has been loaded into the output register. When the
//   duty clamps at 0 or full drive, the rest of the duty scaling is skipped. All
//   work runs through the one shared 20x32 multiplier: rpm scaling, two passes
//   for each of the three gain products, two passes for the duty scaling and
//   one for the divide by 333, with narrow add, compare and saturate steps between them.
// Reset:
//   rst_n clears the error sum, previous error and accumulator, loads the
//   register defaults and empties the output register.
// Stall:
//   the result sits in the output register until taken; the next tick may be
//   accepted meanwhile, and it waits at its end until the register frees up.
module velocity_pid_pwm_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pulse_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] pwm_duty, [23:10] measured_rpm
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RPM_MUL  = 5'd1;
  localparam logic [4:0] S_RPM_FIX  = 5'd2;
  localparam logic [4:0] S_ERR      = 5'd3;
  localparam logic [4:0] S_TERM_LO  = 5'd4;
  localparam logic [4:0] S_TERM_HI  = 5'd5;
  localparam logic [4:0] S_TERM_ACC = 5'd6;
  localparam logic [4:0] S_TERM_SAT = 5'd7;
  localparam logic [4:0] S_PID_SAT  = 5'd8;
  localparam logic [4:0] S_ACC      = 5'd9;
  localparam logic [4:0] S_DCHK     = 5'd10;
  localparam logic [4:0] S_DMH      = 5'd11;
  localparam logic [4:0] S_DT       = 5'd12;
  localparam logic [4:0] S_DQ       = 5'd13;
  localparam logic [4:0] S_DFIX     = 5'd14;
  localparam logic [4:0] S_OUT      = 5'd15;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  vppc_pkg::cfg_regs_t cfg;

  logic [4:0] state_r, state_nxt;
  logic [1:0] term_r, term_nxt;

  logic [16:0]                         x_r, x_nxt;
  logic [vppc_pkg::RPM_W-1:0]          rpm_r, rpm_nxt;
  logic signed [vppc_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic signed [vppc_pkg::ERR_W:0]     dif_r, dif_nxt;
  logic signed [vppc_pkg::ERR_W-1:0]   prev_r, prev_nxt;
  logic signed [vppc_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [vppc_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [vppc_pkg::ACC_W+1:0]   pid_r, pid_nxt;
  logic [71:0]                         prod_r, prod_nxt;
  logic [9:0]                          p0hi_r, p0hi_nxt;
  logic [17:0]                         t_r, t_nxt;
  logic [vppc_pkg::DUTY_W-1:0]         duty_r, duty_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [vppc_pkg::DUTY_W-1:0]         out_duty_r, out_duty_nxt;
  logic [vppc_pkg::RPM_W-1:0]          out_rpm_r, out_rpm_nxt;

  logic [vppc_pkg::MUL_A_W-1:0] mul_a;
  logic [vppc_pkg::MUL_B_W-1:0] mul_b;
  logic [vppc_pkg::MUL_P_W-1:0] mul_p;

  logic [vppc_pkg::GAIN_W-1:0]  gain_sel;
  logic signed [32:0]           opnd_sel;
  logic [32:0]                  mag_full;
  logic [31:0]                  mag;
  logic                         neg;
  logic signed [vppc_pkg::ACC_W-1:0] term;

  logic [13:0] rq0;
  logic [16:0] rrem;
  logic signed [32:0] sum_ext;
  logic signed [vppc_pkg::ACC_W:0] acc_ext;
  logic [9:0]  dq0;
  logic [18:0] drem;
  logic        load_out;

  vppc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  vppc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  // operand and gain of the current pid term
  always_comb begin
    unique case (term_r)
      TERM_P: begin
        gain_sel = cfg.gain_proportional;
        opnd_sel = 33'(err_r);
      end
      TERM_I: begin
        gain_sel = cfg.gain_integral_scaled;
        opnd_sel = 33'(sum_r);
      end
      TERM_D: begin
        gain_sel = cfg.gain_derivative_scaled;
        opnd_sel = 33'(dif_r);
      end
      default: begin
        gain_sel = '0;
        opnd_sel = '0;
      end
    endcase
    neg      = opnd_sel[32];
    mag_full = neg ? 33'(-opnd_sel) : 33'(opnd_sel);
    mag      = mag_full[31:0];
  end

  // saturate the exact product to 48 bits
  always_comb begin
    if (neg) begin
      if ((|prod_r[71:48]) || (prod_r[47] && (|prod_r[46:0]))) begin
        term = {1'b1, {(vppc_pkg::ACC_W-1){1'b0}}};
      end else begin
        term = -$signed(prod_r[47:0]);
      end
    end else begin
      if (|prod_r[71:47]) begin
        term = {1'b0, {(vppc_pkg::ACC_W-1){1'b1}}};
      end else begin
        term = $signed(prod_r[47:0]);
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RPM_MUL: begin
        mul_a = vppc_pkg::RPM_RECIP;
        mul_b = 32'(x_r);
      end
      S_TERM_LO: begin
        mul_a = gain_sel[19:0];
        mul_b = mag;
      end
      S_TERM_HI: begin
        mul_a = gain_sel[39:20];
        mul_b = mag;
      end
      S_DCHK: begin
        mul_a = 20'(vppc_pkg::DUTY_FULL);
        mul_b = acc_r[31:0];
      end
      S_DMH: begin
        mul_a = 20'(vppc_pkg::DUTY_FULL);
        mul_b = 32'(acc_r[40:32]);
      end
      S_DQ: begin
        mul_a = vppc_pkg::DUTY_RECIP;
        mul_b = 32'(t_r);
      end
      default: ;
    endcase
  end

  assign rq0     = mul_p[33:20];
  assign rrem    = x_r - 17'(17'(rq0) * vppc_pkg::RPM_DIV);
  assign sum_ext = 33'(sum_r) + 33'(err_r);
  assign acc_ext = 49'(acc_r) + 49'($signed(pid_r[vppc_pkg::ACC_W-1:0]));
  assign dq0     = mul_p[35:26];
  assign drem    = {1'b0, t_r} - 19'(19'(dq0) * vppc_pkg::DRIVE_FULL);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    term_nxt      = term_r;
    x_nxt         = x_r;
    rpm_nxt       = rpm_r;
    err_nxt       = err_r;
    dif_nxt       = dif_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    pid_nxt       = pid_r;
    prod_nxt      = prod_r;
    p0hi_nxt      = p0hi_r;
    t_nxt         = t_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r;
    out_duty_nxt  = out_duty_r;
    out_rpm_nxt   = out_rpm_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = {1'b0, in_tdata} << 1;
          state_nxt = S_RPM_MUL;
        end
      end
      S_RPM_MUL: state_nxt = S_RPM_FIX;
      S_RPM_FIX: begin
        rpm_nxt   = (rrem >= vppc_pkg::RPM_DIV) ? rq0 + 14'd1 : rq0;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        err_nxt = $signed({2'b00, cfg.setpoint_rpm}) - $signed({4'b0000, rpm_r});
        state_nxt = S_TERM_LO;
        term_nxt  = TERM_P;
        pid_nxt   = '0;
      end
      S_TERM_LO: begin
        if (term_r == TERM_P) begin
          // the running sum and the difference of the error are registered here for the I and D terms
          sum_nxt = (sum_ext[32] != sum_ext[31]) ?
                    {sum_ext[32], {(vppc_pkg::SUM_W-1){~sum_ext[32]}}} :
                    sum_ext[31:0];
          dif_nxt = 19'(err_r) - 19'(prev_r);
        end
        state_nxt = S_TERM_HI;
      end
      S_TERM_HI: begin
        prod_nxt  = 72'(mul_p);
        state_nxt = S_TERM_ACC;
      end
      S_TERM_ACC: begin
        prod_nxt  = prod_r + {mul_p, 20'b0};
        state_nxt = S_TERM_SAT;
      end
      S_TERM_SAT: begin
        pid_nxt = pid_r + 50'(term);
        if (term_r == TERM_D) begin
          state_nxt = S_PID_SAT;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_TERM_LO;
        end
      end
      S_PID_SAT: begin
        if (pid_r[49:47] != 3'b000 && pid_r[49:47] != 3'b111) begin
          pid_nxt = pid_r[49] ? 50'sh3_8000_0000_0000 : 50'sh0_7FFF_FFFF_FFFF;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = (acc_ext[48] != acc_ext[47]) ?
                  {acc_ext[48], {(vppc_pkg::ACC_W-1){~acc_ext[48]}}} :
                  acc_ext[47:0];
        prev_nxt  = err_r;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        priority if (acc_r[47]) begin
          duty_nxt  = '0;
          state_nxt = S_OUT;
        end else if (acc_r[46:32] >= 15'(vppc_pkg::DRIVE_FULL)) begin
          duty_nxt  = vppc_pkg::DUTY_FULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DMH;
        end
      end
      S_DMH: begin
        p0hi_nxt  = mul_p[41:32];
        state_nxt = S_DT;
      end
      S_DT: begin
        t_nxt     = mul_p[17:0] + 18'(p0hi_r);
        state_nxt = S_DQ;
      end
      S_DQ: state_nxt = S_DFIX;
      S_DFIX: begin
        duty_nxt  = (drem >= vppc_pkg::DRIVE_FULL) ? dq0 + 10'd1 : dq0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = duty_r;
          out_rpm_nxt   = rpm_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= TERM_P;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      sum_r       <= '0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    rpm_r      <= rpm_nxt;
    err_r      <= err_nxt;
    dif_r      <= dif_nxt;
    pid_r      <= pid_nxt;
    prod_r     <= prod_nxt;
    p0hi_r     <= p0hi_nxt;
    t_r        <= t_nxt;
    duty_r     <= duty_nxt;
    out_duty_r <= out_duty_nxt;
    out_rpm_r  <= out_rpm_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rpm_r, out_duty_r};

endmodule

FILE: hw/rtl/vppc_mul.sv
// shared 20x32 unsigned multiplier with registered product
module vppc_mul (
  input  logic                         clk,
  input  logic [vppc_pkg::MUL_A_W-1:0] a,
  input  logic [vppc_pkg::MUL_B_W-1:0] b,
  output logic [vppc_pkg::MUL_P_W-1:0] p
);

  logic [vppc_pkg::MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= vppc_pkg::MUL_P_W'(a) * vppc_pkg::MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

FILE: hw/rtl/vppc_cfg.sv
// configuration register file: setpoint and the three gains
module vppc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [vppc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [vppc_pkg::CFG_DATA_W-1:0] wr_data,
  output vppc_pkg::cfg_regs_t             regs
);

  vppc_pkg::cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.setpoint_rpm           <= vppc_pkg::SETPOINT_RST;
      regs_r.gain_proportional      <= vppc_pkg::KP_RST;
      regs_r.gain_integral_scaled   <= vppc_pkg::KI_RST;
      regs_r.gain_derivative_scaled <= vppc_pkg::KD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        vppc_pkg::REG_SETPOINT: regs_r.setpoint_rpm <= wr_data[vppc_pkg::SETPOINT_W-1:0];
        vppc_pkg::REG_KP:       regs_r.gain_proportional <= wr_data;
        vppc_pkg::REG_KI:       regs_r.gain_integral_scaled <= wr_data;
        vppc_pkg::REG_KD:       regs_r.gain_derivative_scaled <= wr_data;
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

FILE: tb/testbench.sv
// self-checking testbench: predicts duty and rpm of every control tick and checks each result beat
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vppc_pkg::*;

  localparam longint DRIVE_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DRIVE_MIN   = -DRIVE_MAX - 1;
  localparam longint FULL_DRIVE  = longint'(DRIVE_FULL) << 32;
  localparam longint ERR_SUM_MAX = 64'sd2147483647;
  localparam longint ERR_SUM_MIN = -ERR_SUM_MAX - 1;

  localparam logic [GAIN_W-1:0]    GAIN_TOP      = '1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_TICKS   = 100;
  localparam int CALM_PHASE    = 5;
  localparam int WINDUP_TICKS  = 100;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [RPM_W-1:0]  rpm;
  } tick_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } reg_write_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [RATE_W-1:0]       in_tdata  = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [DUTY_W+RPM_W-1:0] out_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // controller copy
  logic [SETPOINT_W-1:0]   set_rpm;
  logic [GAIN_W-1:0]       kp, ki_t, kd_t;
  logic signed [ACC_W-1:0] drive_acc;
  logic signed [ERR_W-1:0] last_err;
  logic signed [SUM_W-1:0] err_total;
  bit                      err_total_pinned = 1'b0;

  logic [RATE_W-1:0] pending_rates [$];
  tick_result_t      expected_ticks [$];
  reg_write_t        reg_writes_pending [$];

  bit no_gaps = 1'b0;
  int send_gap, take_hold;
  int cycles, mismatches, ticks_checked, reg_writes_done;
  int duty_low, duty_high, duty_mid;

  velocity_pid_pwm_controller dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_drive(input longint v);
    if (v > DRIVE_MAX) return DRIVE_MAX;
    if (v < DRIVE_MIN) return DRIVE_MIN;
    return v;
  endfunction

  // unsigned q8.32 gain times a signed integer, saturated to 48 bits
  function automatic longint scale_by_gain(input logic [GAIN_W-1:0] gain, input longint x);
    longint             absx;
    logic [31:0]        mag;
    logic [GAIN_W+31:0] prod;
    absx = (x < 0) ? -x : x;
    mag  = absx[31:0];
    prod = gain * mag;
    if (x < 0) return (prod > (72'd1 << 47)) ? DRIVE_MIN : -longint'(prod[47:0]);
    return (prod > 72'(DRIVE_MAX)) ? DRIVE_MAX : longint'(prod[47:0]);
  endfunction

  function automatic tick_result_t pid_tick(input logic [RATE_W-1:0] rate);
    logic [RATE_W:0] rpm;
    longint          speed, setp, prev_e, acc_prev, err, total, delta, pid, drive, scaled;
    tick_result_t    res;
    rpm      = ({1'b0, rate} << 1) / 17'd11;
    speed    = rpm;
    setp     = set_rpm;
    prev_e   = last_err;
    acc_prev = drive_acc;
    total    = err_total;
    err      = setp - speed;
    total    = total + err;
    if (total > ERR_SUM_MAX) begin
      total = ERR_SUM_MAX;
      err_total_pinned = 1'b1;
    end else if (total < ERR_SUM_MIN) begin
      total = ERR_SUM_MIN;
    end
    delta = err - prev_e;
    pid = clamp_drive(scale_by_gain(kp, err) + scale_by_gain(ki_t, total)
                      + scale_by_gain(kd_t, delta));
    drive = clamp_drive(acc_prev + pid);
    err_total = total[SUM_W-1:0];
    last_err  = err[ERR_W-1:0];
    drive_acc = drive[ACC_W-1:0];
    res.rpm = rpm[RPM_W-1:0];
    if (drive >= FULL_DRIVE) begin
      res.duty = DUTY_FULL;
    end else if (drive < 0) begin
      res.duty = '0;
    end else begin
      scaled   = (drive * longint'(DUTY_FULL)) / FULL_DRIVE;
      res.duty = scaled[DUTY_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return GAIN_TOP;
      2:       return {8'($urandom), 32'($urandom)};
      3, 4, 5: return 40'($urandom);
      default: return 40'($urandom_range(32'h03FF_FFFF));
    endcase
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_rates.size() != 0 || in_tvalid || expected_ticks.size() != 0
           || reg_writes_pending.size() != 0 || cfg_valid)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_regs
    reg_write_t next_write;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes_done++;
        case (cfg_index)
          REG_SETPOINT: set_rpm = cfg_data[SETPOINT_W-1:0];
          REG_KP:       kp      = cfg_data;
          REG_KI:       ki_t    = cfg_data;
          REG_KD:       kd_t    = cfg_data;
          default:      ;
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes_pending.size() != 0) begin
          next_write = reg_writes_pending.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_write.index;
          cfg_data  <= next_write.value;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : feed_rates
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_ticks.push_back(pid_tick(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pending_rates.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!no_gaps && send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!no_gaps && $urandom_range(99) < 30) begin
          send_gap  <= $urandom_range(40);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_rates.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin : take_results
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_hold  <= 0;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
    end else if (take_hold != 0) begin
      take_hold  <= take_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < 2) begin
      take_hold  <= $urandom_range(60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin : check_results
    tick_result_t      want;
    logic [DUTY_W-1:0] got_duty;
    logic [RPM_W-1:0]  got_rpm;
    if (rst_n && out_tvalid && out_tready) begin
      got_duty = out_tdata[DUTY_W-1:0];
      got_rpm  = out_tdata[DUTY_W +: RPM_W];
      ticks_checked++;
      if (got_duty == '0) duty_low++;
      else if (got_duty == DUTY_FULL) duty_high++;
      else duty_mid++;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing pending: duty %0d rpm %0d",
                   $time, got_duty, got_rpm);
      end else begin
        want = expected_ticks.pop_front();
        if (got_duty !== want.duty || got_rpm !== want.rpm) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: tick %0d: duty expected %0d got %0d, rpm expected %0d got %0d",
                     $time, ticks_checked, want.duty, got_duty, want.rpm, got_rpm);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SETPOINT_W-1:0] sp;
    int                    target, r;
    set_rpm   = SETPOINT_RST;
    kp        = KP_RST;
    ki_t      = KI_RST;
    kd_t      = KD_RST;
    drive_acc = '0;
    last_err  = '0;
    err_total = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: rate extremes, rpm floor edges, zero error
    pending_rates = {16'd0, 16'd65535, 16'd1375, 16'd5, 16'd6, 16'd11,
                     16'd32767, 16'd32768, 16'd1380};
    wait_idle();

    // full-scale gains, setpoint with junk above its field, dropped indexes
    reg_writes_pending.push_back({REG_SETPOINT, 40'hFF_FFFF_FFFF});
    reg_writes_pending.push_back({REG_KP, GAIN_TOP});
    reg_writes_pending.push_back({REG_KI, GAIN_TOP});
    reg_writes_pending.push_back({REG_KD, GAIN_TOP});
    reg_writes_pending.push_back({REG_SPARE_LOW, 40'h00_0000_1234});
    reg_writes_pending.push_back({REG_SPARE_TOP, 40'hFF_FFFF_FFFF});
    wait_idle();
    pending_rates = {16'd0, 16'd0, 16'd65535};
    wait_idle();

    // negative error drives products and drive low
    reg_writes_pending.push_back({REG_SETPOINT, 40'hAB_CD00_0000});
    wait_idle();
    pending_rates = {16'd65535, 16'd65535, 16'd0, 16'd65535};
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(4))
        0:       sp = '0;
        1:       sp = '1;
        2:       sp = 16'($urandom);
        default: sp = 16'($urandom_range(11915));
      endcase
      reg_writes_pending.push_back({REG_SETPOINT, 24'($urandom), sp});
      reg_writes_pending.push_back({REG_KP, pick_gain()});
      reg_writes_pending.push_back({REG_KI, (p == 0) ? {GAIN_W{1'b0}} : pick_gain()});
      reg_writes_pending.push_back({REG_KD, (p == 0) ? {GAIN_W{1'b0}} : pick_gain()});
      if ($urandom_range(3) == 0)
        reg_writes_pending.push_back({8'($urandom_range(255, 4)), 8'($urandom),
                                      32'($urandom)});
      wait_idle();
      no_gaps = (p == CALM_PHASE);
      target  = (int'(sp) * 11) / 2;
      for (int i = 0; i < PHASE_TICKS; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: r = target + int'($urandom_range(600)) - 300;
          5, 6, 7:       r = int'($urandom_range(65535));
          8:             r = 0;
          default:       r = 65535;
        endcase
        if (r < 0) r = 0;
        else if (r > 65535) r = 65535;
        pending_rates.push_back(r[RATE_W-1:0]);
      end
      wait_idle();
      no_gaps = 1'b0;
    end

    // push the error sum up hard, then pull it back
    reg_writes_pending.push_back({REG_SETPOINT, 24'd0, 16'hFFFF});
    wait_idle();
    no_gaps = 1'b1;
    for (int i = 0; i < WINDUP_TICKS; i++)
      pending_rates.push_back(RATE_W'($urandom_range(10)));
    for (int i = 0; i < 40; i++)
      pending_rates.push_back(RATE_W'($urandom));
    wait_idle();
    no_gaps = 1'b0;
    reg_writes_pending.push_back({REG_SETPOINT, 40'd0});
    wait_idle();
    for (int i = 0; i < 30; i++)
      pending_rates.push_back(16'hFFFF);
    wait_idle();

    repeat (40) @(posedge clk);
    mismatches += expected_ticks.size();
    $display("%0d ticks checked over %0d register writes; duty at zero %0d, full %0d, between %0d",
             ticks_checked, reg_writes_done, duty_low, duty_high, duty_mid);
    $display("error sum %0s its upper limit, %0d mismatches",
             err_total_pinned ? "reached" : "never reached", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/vppc_pkg.sv
hw/rtl/vppc_mul.sv
hw/rtl/vppc_cfg.sv
hw/rtl/velocity_pid_pwm_controller.sv
tb/testbench.sv
